// ===== rtl/csv_byte_tokenizer_unit_assert.svh =====
// Assertion macros shared by the CSV tokenizer checker.
// Each macro expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef CSV_BYTE_TOKENIZER_UNIT_ASSERT_SVH
`define CSV_BYTE_TOKENIZER_UNIT_ASSERT_SVH

// Same-cycle implication, checked only outside reset.
`define CSVTOK_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("csv tokenizer check failed");

// Next-cycle implication, checked only outside reset.
`define CSVTOK_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("csv tokenizer check failed");

`endif

// ===== rtl/csvtok_pkg.sv =====
// Package for the CSV byte tokenizer: payload types, parse modes, constants
// and the per-byte parse function. Depends on nothing.
`timescale 1ns / 1ps

package csvtok_pkg;

    localparam int unsigned MaxResults = 4;

    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_LF = 8'h0A;
    localparam logic [7:0] BOM_0   = 8'hEF;
    localparam logic [7:0] BOM_1   = 8'hBB;
    localparam logic [7:0] BOM_2   = 8'hBF;

    localparam logic       STRIP_BOM_RESET = 1'b1;
    localparam logic [7:0] SEPARATOR_RESET = 8'd44;
    localparam logic [7:0] QUOTE_RESET     = 8'd34;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_STRIP_BOM = 2'd0,
        CFG_SEPARATOR = 2'd1,
        CFG_QUOTE     = 2'd2
    } cfg_index_t;

    // Parse mode of the current field.
    typedef enum logic [1:0] {
        MODE_UNQUOTED = 2'd0,
        MODE_QUOTED   = 2'd1,
        MODE_PENDING  = 2'd2
    } parse_mode_t;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       field_end;
        logic       row_end;
        logic       stream_end;
        logic       run_last;
    } out_item_t;

    // Parser state after one byte, plus the result that byte gave, if any.
    typedef struct packed {
        parse_mode_t mode;
        logic        nonempty;
        logic        res_valid;
        out_item_t   res;
    } step_t;

    function automatic logic [7:0] bom_byte(input logic [1:0] idx);
        logic [7:0] val;
        case (idx)
            2'd0: val = BOM_0;
            2'd1: val = BOM_1;
            2'd2: val = BOM_2;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

    function automatic out_item_t data_res(input logic [7:0] b);
        out_item_t r;
        r = '0;
        r.data_byte  = b;
        r.byte_valid = 1'b1;
        return r;
    endfunction

    // Handles one byte of the stream against the current mode.
    function automatic step_t handle_byte(
        input parse_mode_t mode,
        input logic        nonempty,
        input logic [7:0]  b,
        input logic [7:0]  sep,
        input logic [7:0]  quote
    );
        step_t s;
        s           = '0;
        s.mode      = mode;
        s.nonempty  = nonempty;
        if (mode == MODE_PENDING && b == quote) begin
            // Doubled quote inside a quoted field gives one quote byte.
            s.res_valid = 1'b1;
            s.res       = data_res(b);
            s.nonempty  = 1'b1;
            s.mode      = MODE_QUOTED;
        end else if (mode == MODE_QUOTED) begin
            if (b == quote) begin
                s.mode = MODE_PENDING;
            end else begin
                s.res_valid = 1'b1;
                s.res       = data_res(b);
                s.nonempty  = 1'b1;
            end
        end else begin
            // Unquoted, or a pending quote that turned out to close the field.
            s.mode = MODE_UNQUOTED;
            if (b == quote) begin
                if (!nonempty) begin
                    s.mode = MODE_QUOTED;
                end else begin
                    s.res_valid = 1'b1;
                    s.res       = data_res(b);
                end
            end else if (b == sep) begin
                s.res_valid     = 1'b1;
                s.res.field_end = 1'b1;
                s.nonempty      = 1'b0;
            end else if (b == BYTE_CR) begin
                s.res_valid     = 1'b1;
                s.res.field_end = 1'b1;
                s.res.row_end   = 1'b1;
                s.nonempty      = 1'b0;
            end else if (b != BYTE_LF) begin
                s.res_valid = 1'b1;
                s.res       = data_res(b);
                s.nonempty  = 1'b1;
            end
        end
        return s;
    endfunction

endpackage

// ===== rtl/csv_byte_tokenizer_unit.sv =====
// CSV byte tokenizer (RFC 4180 style). Raw stream bytes enter on the s_ channel, one
// per transfer, and leave on the m_ channel as field bytes, field ends and row ends; each
// result carries run_last on the last result of its input byte and stream_end on the
// final result of a stream. A leading UTF-8 byte order mark is dropped when strip_bom is
// set; a partial mark is replayed as ordinary bytes. Bytes pass through an input register
// and are parsed in one short combinational pass into a four-entry result buffer, which
// drains one result per cycle while m_ready is high. A plain stream, whose bytes give
// zero or one result each, then runs at one byte per cycle; a byte that gives more
// results (at most four, at a broken byte order mark or at end of input) holds the
// input until the single output port has drained them one by one. The configuration port
// is written through cfg_wr_en, cfg_addr and cfg_wdata; index 0 is strip_bom, 1 the
// separator, 2 the quote byte. Write it only while the block is idle.
// Depends on csvtok_pkg.
`timescale 1ns / 1ps

module csv_byte_tokenizer_unit (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_addr,
    input  logic [7:0]           cfg_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  csvtok_pkg::in_item_t s_data,

    output logic                  m_valid,
    input  logic                  m_ready,
    output csvtok_pkg::out_item_t m_data
);

    // Configuration registers.
    logic       strip_bom_reg;
    logic [7:0] separator_reg;
    logic [7:0] quote_reg;

    // Input register.
    logic                 in_valid_reg;
    csvtok_pkg::in_item_t in_item_reg;

    // Parser state.
    csvtok_pkg::parse_mode_t mode_reg, mode_next;
    logic                    nonempty_reg, nonempty_next;
    logic [1:0]              bom_reg, bom_next;

    // Result buffer: entries are loaded all at once and read out from head_reg.
    csvtok_pkg::out_item_t res_reg  [csvtok_pkg::MaxResults];
    csvtok_pkg::out_item_t res_next [csvtok_pkg::MaxResults];
    logic [1:0]            head_reg, head_next;
    logic [2:0]            cnt_reg, cnt_next;

    logic pop;
    logic advance;

    // Parse pass signals.
    logic              bom_match;
    logic [1:0]        replay;
    logic              do_cur;
    csvtok_pkg::step_t base, h0, st1, h1, st2, h2, st3;
    logic              slot_valid [csvtok_pkg::MaxResults];
    csvtok_pkg::out_item_t slot_res [csvtok_pkg::MaxResults];
    logic [2:0]        n_res;

    // The buffer can take the next item when it is empty or its last entry leaves now.
    assign pop     = m_valid && m_ready;
    assign advance = in_valid_reg && ((cnt_reg == 3'd0) || (cnt_reg == 3'd1 && m_ready));
    assign s_ready = !in_valid_reg || advance;

    assign m_valid = (cnt_reg != 3'd0);
    assign m_data  = res_reg[head_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strip_bom_reg <= csvtok_pkg::STRIP_BOM_RESET;
            separator_reg <= csvtok_pkg::SEPARATOR_RESET;
            quote_reg     <= csvtok_pkg::QUOTE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                csvtok_pkg::CFG_STRIP_BOM: strip_bom_reg <= cfg_wdata[0];
                csvtok_pkg::CFG_SEPARATOR: separator_reg <= cfg_wdata;
                csvtok_pkg::CFG_QUOTE:     quote_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_data;
        end
    end

    // Byte order mark handling decides which bytes go through the parser this pass:
    // up to two replayed mark bytes (always EF then BB), then the current byte.
    always_comb begin
        bom_match = (bom_reg != 2'd3) && strip_bom_reg
                    && (in_item_reg.byte_in == csvtok_pkg::bom_byte(bom_reg));
        replay   = 2'd0;
        do_cur   = 1'b1;
        bom_next = 2'd3;
        if (bom_reg != 2'd3) begin
            if (bom_match) begin
                do_cur   = 1'b0;
                bom_next = bom_reg + 2'd1;
                // A mark cut short by end of input is replayed, current byte included.
                if (in_item_reg.end_of_input && bom_reg != 2'd2) begin
                    replay = bom_reg + 2'd1;
                end
            end else begin
                replay = bom_reg;
            end
        end
    end

    // Three chained parse steps: replayed EF, replayed BB, current byte.
    always_comb begin
        base          = '0;
        base.mode     = mode_reg;
        base.nonempty = nonempty_reg;
        h0  = csvtok_pkg::handle_byte(base.mode, base.nonempty, csvtok_pkg::BOM_0,
                                      separator_reg, quote_reg);
        st1 = (replay != 2'd0) ? h0 : base;
        h1  = csvtok_pkg::handle_byte(st1.mode, st1.nonempty, csvtok_pkg::BOM_1,
                                      separator_reg, quote_reg);
        st2 = (replay == 2'd2) ? h1 : st1;
        h2  = csvtok_pkg::handle_byte(st2.mode, st2.nonempty, in_item_reg.byte_in,
                                      separator_reg, quote_reg);
        st3 = do_cur ? h2 : st2;

        slot_valid[0] = (replay != 2'd0) && h0.res_valid;
        slot_res[0]   = h0.res;
        slot_valid[1] = (replay == 2'd2) && h1.res_valid;
        slot_res[1]   = h1.res;
        slot_valid[2] = do_cur && h2.res_valid;
        slot_res[2]   = h2.res;
        // End of input closes a field that holds data.
        slot_valid[3]           = in_item_reg.end_of_input && st3.nonempty;
        slot_res[3]             = '0;
        slot_res[3].field_end   = 1'b1;
    end

    // Pack the results that exist into the front of the buffer and mark the last one.
    always_comb begin
        for (int i = 0; i < csvtok_pkg::MaxResults; i++) begin
            res_next[i] = '0;
        end
        n_res = 3'd0;
        for (int i = 0; i < csvtok_pkg::MaxResults; i++) begin
            if (slot_valid[i]) begin
                res_next[n_res[1:0]] = slot_res[i];
                n_res = n_res + 3'd1;
            end
        end
        // A stream end with nothing else to report still gives one empty result.
        if (in_item_reg.end_of_input && n_res == 3'd0) begin
            n_res = 3'd1;
        end
        for (int i = 0; i < csvtok_pkg::MaxResults; i++) begin
            if (3'(i) == n_res - 3'd1) begin
                res_next[i].run_last   = 1'b1;
                res_next[i].stream_end = in_item_reg.end_of_input;
            end
        end
    end

    // Parser state update: everything returns to stream start after end of input.
    always_comb begin
        mode_next     = mode_reg;
        nonempty_next = nonempty_reg;
        if (advance) begin
            if (in_item_reg.end_of_input) begin
                mode_next     = csvtok_pkg::MODE_UNQUOTED;
                nonempty_next = 1'b0;
            end else begin
                mode_next     = st3.mode;
                nonempty_next = st3.nonempty;
            end
        end
    end

    always_comb begin
        head_next = head_reg;
        cnt_next  = cnt_reg;
        if (advance) begin
            head_next = 2'd0;
            cnt_next  = n_res;
        end else if (pop) begin
            head_next = head_reg + 2'd1;
            cnt_next  = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= csvtok_pkg::MODE_UNQUOTED;
            nonempty_reg <= 1'b0;
            bom_reg      <= 2'd0;
            head_reg     <= 2'd0;
            cnt_reg      <= 3'd0;
        end else begin
            mode_reg     <= mode_next;
            nonempty_reg <= nonempty_next;
            head_reg     <= head_next;
            cnt_reg      <= cnt_next;
            if (advance) begin
                bom_reg <= in_item_reg.end_of_input ? 2'd0 : bom_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int i = 0; i < csvtok_pkg::MaxResults; i++) begin
                res_reg[i] <= res_next[i];
            end
        end
    end

endmodule

// ===== rtl/csvtok_checker.sv =====
// Port-level checker for the CSV byte tokenizer, bound into csv_byte_tokenizer_unit.
// Depends on csvtok_pkg and csv_byte_tokenizer_unit_assert.svh.
`timescale 1ns / 1ps
`include "csv_byte_tokenizer_unit_assert.svh"

module csvtok_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input csvtok_pkg::out_item_t m_data
);

    // A stalled result transfer keeps its payload.
    `CSVTOK_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))
    // A row end always closes the field too.
    `CSVTOK_ASSERT_NOW(a_row_has_field, m_valid && m_data.row_end, m_data.field_end)
    // Only data results carry a byte.
    `CSVTOK_ASSERT_NOW(a_no_stray_byte, m_valid && !m_data.byte_valid, m_data.data_byte == 8'h00)
    // The end of the stream is also the last result of its byte.
    `CSVTOK_ASSERT_NOW(a_stream_end_last, m_valid && m_data.stream_end, m_data.run_last)
    // A data byte never ends a field in the same result.
    `CSVTOK_ASSERT_NOW(a_data_not_end, m_valid && m_data.byte_valid, !m_data.field_end)

endmodule

bind csv_byte_tokenizer_unit csvtok_checker u_csvtok_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== verif/csv_byte_tokenizer_unit_tb.sv =====
// Self-checking testbench for csv_byte_tokenizer_unit: directed CSV streams, register
// sweeps and random traffic, checked against an in-bench token predictor.
// Depends on csvtok_pkg and csv_byte_tokenizer_unit.
`timescale 1ns / 1ps

module csv_byte_tokenizer_unit_tb;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 12;
    // Cycles with no transfer on either channel before the run is declared hung.
    localparam int STALL_LIMIT  = 2000;
    // Input register plus a four-entry result buffer; a byte that gives no token
    // can still be in flight when the token queue runs empty.
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 70;

    localparam logic [7:0] BOM_SEQ [3] = '{csvtok_pkg::BOM_0, csvtok_pkg::BOM_1,
                                           csvtok_pkg::BOM_2};

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      cfg_wr_en;
    logic [1:0] cfg_addr;
    logic [7:0] cfg_wdata;
    logic      s_valid;
    logic      s_ready;
    csvtok_pkg::in_item_t  s_data;
    logic      m_valid;
    logic      m_ready = 1'b0;
    csvtok_pkg::out_item_t m_data;

    csv_byte_tokenizer_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor state. The register copies are updated by the write task,
    // which only runs while the block is idle; the parse state advances
    // once per accepted input transfer.
    // ------------------------------------------------------------------
    logic        cfg_strip;
    logic [7:0]  cfg_sep;
    logic [7:0]  cfg_quote;
    csvtok_pkg::parse_mode_t tok_mode = csvtok_pkg::MODE_UNQUOTED;
    logic        tok_nonempty = 1'b0;
    logic [1:0]  bom_matched = 2'd0; // 3 means the stream start is behind us

    csvtok_pkg::out_item_t step_tokens[$];    // tokens of the byte being predicted
    csvtok_pkg::out_item_t pending_tokens[$]; // tokens still owed by the block
    csvtok_pkg::in_item_t  stream_q[$];       // bytes of the stream being built

    int  errors;
    int  items_sent;
    int  stall_cycles;
    bit  quiet_mode;               // when set, neither side inserts gaps
    csvtok_pkg::out_item_t want;

    function automatic bit take_gap();
        return !quiet_mode && ($urandom_range(99) < 21);
    endfunction

    function automatic csvtok_pkg::out_item_t token(input logic [7:0] d, input logic v,
                                                    input logic fe, input logic re);
        csvtok_pkg::out_item_t t;
        t            = '0;
        t.data_byte  = d;
        t.byte_valid = v;
        t.field_end  = fe;
        t.row_end    = re;
        return t;
    endfunction

    // Appends one token to the tokens of the current byte.
    task automatic add_token(input csvtok_pkg::out_item_t t);
        step_tokens.insert(step_tokens.size(), t);
    endtask

    // Runs one byte through the field and quote state machine.
    task automatic parse_byte(input logic [7:0] b);
        bit done;
        done = 1'b0;
        // A quote seen inside a quoted field is held until the next byte shows
        // whether it was doubled (a literal quote) or closed the quoted part.
        if (tok_mode == csvtok_pkg::MODE_PENDING) begin
            if (b == cfg_quote) begin
                add_token(token(b, 1'b1, 1'b0, 1'b0));
                tok_nonempty = 1'b1;
                tok_mode     = csvtok_pkg::MODE_QUOTED;
                done         = 1'b1;
            end else begin
                tok_mode = csvtok_pkg::MODE_UNQUOTED;
            end
        end
        if (!done) begin
            if (tok_mode == csvtok_pkg::MODE_QUOTED) begin
                if (b == cfg_quote) begin
                    tok_mode = csvtok_pkg::MODE_PENDING;
                end else begin
                    add_token(token(b, 1'b1, 1'b0, 1'b0));
                    tok_nonempty = 1'b1;
                end
            end else begin
                // Outside quotes the quote byte wins over the separator, which
                // wins over CR, which wins over LF.
                tok_mode = csvtok_pkg::MODE_UNQUOTED;
                if (b == cfg_quote) begin
                    if (!tok_nonempty) begin
                        tok_mode = csvtok_pkg::MODE_QUOTED;
                    end else begin
                        add_token(token(b, 1'b1, 1'b0, 1'b0));
                    end
                end else if (b == cfg_sep) begin
                    add_token(token(8'h00, 1'b0, 1'b1, 1'b0));
                    tok_nonempty = 1'b0;
                end else if (b == csvtok_pkg::BYTE_CR) begin
                    add_token(token(8'h00, 1'b0, 1'b1, 1'b1));
                    tok_nonempty = 1'b0;
                end else if (b != csvtok_pkg::BYTE_LF) begin
                    add_token(token(b, 1'b1, 1'b0, 1'b0));
                    tok_nonempty = 1'b1;
                end
            end
        end
    endtask

    // Byte order mark matched so far goes back through the parser as data.
    task automatic replay_bom();
        for (int i = 0; i < bom_matched; i++) begin
            parse_byte(BOM_SEQ[i]);
        end
    endtask

    // Works out every token one accepted input byte causes and queues them.
    task automatic predict_tokens(input csvtok_pkg::in_item_t it);
        int last;
        step_tokens.delete();
        if (bom_matched != 2'd3) begin
            if (cfg_strip && it.byte_in == BOM_SEQ[bom_matched]) begin
                bom_matched = bom_matched + 2'd1;
                // A mark cut short by the end of the stream is plain data.
                if (bom_matched != 2'd3 && it.end_of_input) begin
                    replay_bom();
                    bom_matched = 2'd3;
                end
            end else begin
                replay_bom();
                bom_matched = 2'd3;
                parse_byte(it.byte_in);
            end
        end else begin
            parse_byte(it.byte_in);
        end

        if (it.end_of_input) begin
            // A pending quote simply closes; only a non-empty field is ended.
            if (tok_nonempty) begin
                add_token(token(8'h00, 1'b0, 1'b1, 1'b0));
            end
            // With nothing else to say, an empty token carries the stream end.
            if (step_tokens.size() == 0) begin
                add_token(token(8'h00, 1'b0, 1'b0, 1'b0));
            end
            step_tokens[step_tokens.size() - 1].stream_end = 1'b1;
            tok_mode     = csvtok_pkg::MODE_UNQUOTED;
            tok_nonempty = 1'b0;
            bom_matched  = 2'd0;
        end
        last = step_tokens.size() - 1;
        if (last >= 0) begin
            step_tokens[last].run_last = 1'b1;
        end
        foreach (step_tokens[i]) begin
            pending_tokens.insert(pending_tokens.size(), step_tokens[i]);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor. Both channels are sampled at the rising edge in one process:
    // an input transfer is predicted before a result transfer of the same
    // edge is checked, so the order of events within the step never matters.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if (s_valid && s_ready) begin
                predict_tokens(s_data);
            end
            if (m_valid && m_ready) begin
                if (pending_tokens.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %p",
                             $time, m_data);
                    errors++;
                end else begin
                    want = pending_tokens.pop_front();
                    check_field("data_byte",  want.data_byte,  m_data.data_byte);
                    check_field("byte_valid", want.byte_valid, m_data.byte_valid);
                    check_field("field_end",  want.field_end,  m_data.field_end);
                    check_field("row_end",    want.row_end,    m_data.row_end);
                    check_field("stream_end", want.stream_end, m_data.stream_end);
                    check_field("run_last",   want.run_last,   m_data.run_last);
                end
            end
        end
    end

    // Watchdog: any transfer on either channel restarts the count.
    always @(posedge aclk) begin
        if (aresetn !== 1'b1 || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side back-pressure, redrawn every cycle at the falling edge.
    always @(negedge aclk) begin
        m_ready <= !take_gap();
    end

    // ------------------------------------------------------------------
    // Drivers. Everything changes at the falling edge.
    // ------------------------------------------------------------------

    // Offers one byte and returns at the edge where it is accepted. Valid stays
    // high afterward, so back-to-back calls stream without a bubble unless a gap is drawn.
    task automatic send_item(input csvtok_pkg::in_item_t it);
        @(negedge aclk);
        while (take_gap()) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (s_ready !== 1'b1);
        items_sent++;
    endtask

    // Stops the sender and waits until every owed token has arrived, then lets
    // any byte that gives no token work its way out of the block.
    task automatic settle_block();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_tokens.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input csvtok_pkg::cfg_index_t idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            csvtok_pkg::CFG_STRIP_BOM: cfg_strip = val[0];
            csvtok_pkg::CFG_SEPARATOR: cfg_sep   = val;
            csvtok_pkg::CFG_QUOTE:     cfg_quote = val;
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic strip, input logic [7:0] sep,
                                 input logic [7:0] quote);
        settle_block();
        write_reg(csvtok_pkg::CFG_STRIP_BOM, {7'd0, strip});
        write_reg(csvtok_pkg::CFG_SEPARATOR, sep);
        write_reg(csvtok_pkg::CFG_QUOTE, quote);
    endtask

    // ------------------------------------------------------------------
    // Stream builders.
    // ------------------------------------------------------------------
    task automatic add_byte(input logic [7:0] b, input logic eoi = 1'b0);
        csvtok_pkg::in_item_t it;
        it.byte_in      = b;
        it.end_of_input = eoi;
        stream_q.insert(stream_q.size(), it);
    endtask

    // Sends the built bytes; a CSV stream gets end_of_input on its last byte.
    task automatic send_stream(input bit mark_end);
        if (mark_end) begin
            stream_q[stream_q.size() - 1].end_of_input = 1'b1;
        end
        foreach (stream_q[i]) begin
            send_item(stream_q[i]);
        end
        stream_q.delete();
    endtask

    // Mostly arbitrary bytes, with the bytes that steer the parser mixed in.
    function automatic logic [7:0] pick_content();
        logic [7:0] b;
        if ($urandom_range(99) < 75) begin
            b = 8'($urandom_range(255));
        end else begin
            case ($urandom_range(6))
                0: b = cfg_quote;
                1: b = csvtok_pkg::BOM_0;
                2: b = csvtok_pkg::BOM_1;
                3: b = csvtok_pkg::BOM_2;
                4: b = 8'h00;
                5: b = 8'hFF;
                default: b = csvtok_pkg::BYTE_LF;
            endcase
        end
        return b;
    endfunction

    task automatic build_field();
        logic [7:0] b;
        int kind;
        kind = $urandom_range(99);
        if (kind < 35) begin
            // Quoted field with doubled quotes sprinkled in.
            add_byte(cfg_quote);
            repeat ($urandom_range(4)) begin
                b = ($urandom_range(3) == 0) ? cfg_quote : pick_content();
                add_byte(b);
                if (b == cfg_quote) begin
                    add_byte(b);
                end
            end
            add_byte(cfg_quote);
        end else if (kind < 90) begin
            repeat ($urandom_range(1, 4)) add_byte(pick_content());
        end
    endtask

    // A well formed stream: optional byte order mark (whole or broken), then
    // one to three rows of one to three fields.
    task automatic build_csv_stream();
        int rows;
        int cols;
        case ($urandom_range(5))
            0: begin
                add_byte(csvtok_pkg::BOM_0);
                add_byte(csvtok_pkg::BOM_1);
                add_byte(csvtok_pkg::BOM_2);
            end
            1: begin
                add_byte(csvtok_pkg::BOM_0);
                if ($urandom_range(1)) add_byte(csvtok_pkg::BOM_1);
            end
            default: ;
        endcase
        rows = $urandom_range(1, 3);
        for (int r = 0; r < rows; r++) begin
            cols = $urandom_range(1, 3);
            for (int c = 0; c < cols; c++) begin
                build_field();
                if (c < cols - 1) add_byte(cfg_sep);
            end
            if (r < rows - 1 || $urandom_range(1)) begin
                add_byte(csvtok_pkg::BYTE_CR);
                if ($urandom_range(1)) add_byte(csvtok_pkg::BYTE_LF);
            end
        end
        if (stream_q.size() == 0) begin
            add_byte(8'($urandom_range(255)));
        end
    endtask

    // Raw bytes with an occasional end of input anywhere.
    task automatic build_noise();
        repeat ($urandom_range(1, 8)) begin
            add_byte(8'($urandom_range(255)), ($urandom_range(7) == 0));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Reset settings: a whole mark is dropped, a quoted field with a doubled
    // quote, a closing quote followed by the separator, a quote inside an
    // unquoted field, a dropped LF, CR ending a row, and the byte extremes,
    // with end of input closing the last non-empty field.
    task automatic test_default_stream();
        add_byte(csvtok_pkg::BOM_0);
        add_byte(csvtok_pkg::BOM_1);
        add_byte(csvtok_pkg::BOM_2);
        add_byte(cfg_quote);
        add_byte("a");
        add_byte(cfg_quote);
        add_byte(cfg_quote);
        add_byte(cfg_quote);
        add_byte(cfg_sep);
        add_byte("c");
        add_byte(cfg_quote);
        add_byte(csvtok_pkg::BYTE_LF);
        add_byte(csvtok_pkg::BYTE_CR);
        add_byte(8'h00);
        add_byte(8'hFF);
        send_stream(1'b1);
    endtask

    // A mark broken by a data byte after one and after two bytes, and a mark
    // cut short by end of input.
    task automatic test_broken_bom();
        add_byte(csvtok_pkg::BOM_0);
        add_byte(csvtok_pkg::BOM_1);
        add_byte("A");
        send_stream(1'b1);
        add_byte(csvtok_pkg::BOM_0);
        add_byte("z");
        send_stream(1'b1);
        add_byte(csvtok_pkg::BOM_0);
        add_byte(csvtok_pkg::BOM_1);
        send_stream(1'b1);
    endtask

    // A quote still pending at end of input, and an end of input with nothing
    // to report at all.
    task automatic test_end_of_input();
        add_byte(cfg_quote);
        add_byte("q");
        add_byte(cfg_quote);
        send_stream(1'b1);
        add_byte(csvtok_pkg::BYTE_LF);
        send_stream(1'b1);
    endtask

    task automatic run_setting(input logic strip, input logic [7:0] sep,
                               input logic [7:0] quote);
        apply_setting(strip, sep, quote);
        build_csv_stream();
        send_stream(1'b1);
        build_noise();
        send_stream(1'b0);
    endtask

    // Register extremes, and separator and quote on top of CR and LF to show
    // which byte takes priority.
    task automatic test_register_settings();
        run_setting(1'b0, 8'h00, 8'hFF);
        run_setting(1'b1, 8'hFF, 8'h00);
        run_setting(1'b1, csvtok_pkg::BYTE_CR, csvtok_pkg::BYTE_LF);
        run_setting(1'b0, ";", "'");
        run_setting(csvtok_pkg::STRIP_BOM_RESET, csvtok_pkg::SEPARATOR_RESET,
                    csvtok_pkg::QUOTE_RESET);
    endtask

    // Bulk traffic: mostly well formed streams, some raw noise. One stretch of
    // rounds runs with no gaps on either side, and now and then the sender
    // waits for the block to drain, sometimes picking new register values.
    task automatic test_random_traffic();
        int goal;
        int round;
        goal  = items_sent + RANDOM_ITEMS;
        round = 0;
        while (items_sent < goal) begin
            quiet_mode = (round >= 1 && round < 4);
            if ($urandom_range(99) < 75) begin
                build_csv_stream();
                send_stream(1'b1);
            end else begin
                build_noise();
                send_stream(1'b0);
            end
            if ($urandom_range(9) == 0) begin
                if ($urandom_range(1)) begin
                    apply_setting(1'($urandom_range(1)), 8'($urandom_range(255)),
                                  8'($urandom_range(255)));
                end else begin
                    settle_block();
                end
            end
            round++;
        end
        quiet_mode = 1'b0;
    endtask

    initial begin
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_addr     = csvtok_pkg::CFG_STRIP_BOM;
        cfg_wdata    = 8'h00;
        s_valid      = 1'b0;
        s_data       = '0;
        items_sent   = 0;
        quiet_mode   = 1'b0;
        cfg_strip    = csvtok_pkg::STRIP_BOM_RESET;
        cfg_sep      = csvtok_pkg::SEPARATOR_RESET;
        cfg_quote    = csvtok_pkg::QUOTE_RESET;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_default_stream();
        test_broken_bom();
        test_end_of_input();
        test_register_settings();
        test_random_traffic();

        // Drain the result channel and give stray results a chance to show.
        settle_block();

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
